// ----- hdl/btf_pkg.sv -----
// shared types, constants and helpers of the battery telemetry filter
// no dependencies; imported by btf_ctrl, btf_dpath and the top level
package btf_pkg;

  // widths of the fixed fields
  localparam int unsigned VSAMPLE_W   = 10;
  localparam int unsigned CSAMPLE_W   = 8;
  localparam int unsigned VOLT_W      = 14;
  localparam int unsigned CUR_W       = 8;
  localparam int unsigned PWR_W       = 22;
  localparam int unsigned WATT_W      = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam int unsigned MUL_W       = 24;
  localparam int unsigned ADC_BITS_DEF = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VSHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CSHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VSCALE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RPACK  = 2'd3;

  // register reset values
  localparam logic [3:0]  VSHIFT_RST = 4'd2;
  localparam logic [3:0]  CSHIFT_RST = 4'd2;
  localparam logic [13:0] VSCALE_RST = 14'd866;
  localparam logic [9:0]  RPACK_RST  = 10'd0;

  localparam logic [3:0] MAX_SHIFT = 4'd8;

  // reciprocal multipliers for division by constants
  localparam logic [MUL_W-1:0] RCP125 = 24'd2147484;
  localparam int unsigned      RCP125_SH = 28;
  localparam logic [MUL_W-1:0] RCP25 = 24'd2684355;
  localparam int unsigned      RCP25_SH = 26;
  localparam logic [MUL_W-1:0] RCP5 = 24'd52429;
  localparam int unsigned      RCP5_SH = 18;

  localparam logic [31:0]       VOLT_SAT_LIM = 32'd16384000;
  localparam logic [VOLT_W-1:0] V14_MAX = 14'd16383;
  localparam logic [WATT_W-1:0] WSTEP_LO = 16'd200;
  localparam logic [WATT_W-1:0] WSTEP_HI = 16'd400;

  // multiplier operations
  localparam logic [2:0] OP_VSCALE = 3'd0;
  localparam logic [2:0] OP_VDIV   = 3'd1;
  localparam logic [2:0] OP_RCUR   = 3'd2;
  localparam logic [2:0] OP_SDIV   = 3'd3;
  localparam logic [2:0] OP_PWR    = 3'd4;
  localparam logic [2:0] OP_WDIV   = 3'd5;
  localparam logic [2:0] OP_STEP   = 3'd6;
  localparam logic [2:0] OP_QMUL   = 3'd7;

  typedef struct packed {
    logic [3:0]  vshift;
    logic [3:0]  cshift;
    logic [13:0] vscale;
    logic [9:0]  rpack;
  } cfg_t;

  typedef struct packed {
    logic [2:0] op;
    logic       mul_en;
    logic       load_in;
    logic       acc_en;
    logic       shf_en;
    logic       volt_en;
    logic       sag_en;
    logic       pw_en;
    logic       w_en;
    logic       qsel_en;
    logic       out_load;
  } cmd_t;

  function automatic logic [3:0] clamp_shift(input logic [3:0] s);
    clamp_shift = (s > MAX_SHIFT) ? MAX_SHIFT : s;
  endfunction

endpackage

// ----- hdl/btf_ctrl.sv -----
// sequencer of the battery telemetry filter: issues datapath commands per step
// and runs the input and output handshakes; depends on btf_pkg
module btf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output btf_pkg::cmd_t cmd_o
);
  import btf_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_VSCALE = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_SHF    = 4'd3;
  localparam logic [3:0] S_VDIV   = 4'd4;
  localparam logic [3:0] S_VOLT   = 4'd5;
  localparam logic [3:0] S_SDIV   = 4'd6;
  localparam logic [3:0] S_SAG    = 4'd7;
  localparam logic [3:0] S_PWR    = 4'd8;
  localparam logic [3:0] S_WDIV   = 4'd9;
  localparam logic [3:0] S_STEP   = 4'd10;
  localparam logic [3:0] S_QMUL   = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_VSCALE;
        end
      end
      S_VSCALE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_VSCALE;
        state_d      = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = S_SHF;
      end
      S_SHF: begin
        cmd_o.shf_en = 1'b1;
        state_d      = S_VDIV;
      end
      S_VDIV: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_VDIV;
        state_d      = S_VOLT;
      end
      S_VOLT: begin
        cmd_o.volt_en = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.op      = OP_RCUR;
        state_d       = S_SDIV;
      end
      S_SDIV: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_SDIV;
        state_d      = S_SAG;
      end
      S_SAG: begin
        cmd_o.sag_en = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_PWR;
        state_d      = S_PWR;
      end
      S_PWR: begin
        cmd_o.pw_en  = 1'b1;
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_WDIV;
        state_d      = S_WDIV;
      end
      S_WDIV: begin
        cmd_o.w_en = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        cmd_o.qsel_en = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.op      = OP_STEP;
        state_d       = S_QMUL;
      end
      S_QMUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.op     = OP_QMUL;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result word never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a stalled word");

  // an accepted word starts the sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_VSCALE))
    else $error("accepted word did not start the sequence");

  // one word in flight: no result loaded in the cycle a word enters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_in, cmd_o.acc_en, cmd_o.out_load}))
    else $error("conflicting datapath commands");

  // done is reached only through the final multiply
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> ($past(state_q) == S_QMUL || $past(state_q) == S_DONE))
    else $error("done entered out of order");

endmodule

// ----- hdl/btf_dpath.sv -----
// datapath of the battery telemetry filter: averages, shared 24x24 multiplier,
// reciprocal divisions and result registers; depends on btf_pkg
module btf_dpath #(
  parameter int unsigned AdcBits = btf_pkg::ADC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  btf_pkg::cmd_t                   cmd_i,
  input  btf_pkg::cfg_t                   cfg_i,
  input  logic [btf_pkg::VSAMPLE_W-1:0]   voltage_sample_i,
  input  logic [btf_pkg::CSAMPLE_W-1:0]   current_sample_i,
  output logic [btf_pkg::VOLT_W-1:0]      voltage_tenths_o,
  output logic [btf_pkg::CUR_W-1:0]       current_fifths_o,
  output logic [btf_pkg::PWR_W-1:0]       power_fiftieths_o,
  output logic [btf_pkg::WATT_W-1:0]      power_watts_o,
  output logic [btf_pkg::VOLT_W-1:0]      sag_voltage_tenths_o
);
  import btf_pkg::*;

  localparam int unsigned VsW = (AdcBits < VSAMPLE_W) ? AdcBits : VSAMPLE_W;

  localparam logic [1:0] STEP_10 = 2'd0;
  localparam logic [1:0] STEP_20 = 2'd1;
  localparam logic [1:0] STEP_25 = 2'd2;

  logic [VsW-1:0]       vs_q;
  logic [CSAMPLE_W-1:0] cs_q;
  logic [31:0]          vacc_q, vacc_d;
  logic [15:0]          cacc_q, cacc_d;
  logic [31:0]          xv_q;
  logic [CUR_W-1:0]     cur_q, cur_d;
  logic [VOLT_W-1:0]    volt_q, volt_d;
  logic [VOLT_W-1:0]    sag_q, sag_d;
  logic [PWR_W-1:0]     pw_q;
  logic [WATT_W-1:0]    w_q, w_d;
  logic [1:0]           qsel_q, qsel_d;
  logic [2*MUL_W-1:0]   mult_q;
  logic [MUL_W-1:0]     mul_a, mul_b;

  logic [3:0]  vsh, csh;
  logic [32:0] vsum;
  logic [16:0] csum;
  logic [15:0] cshifted;
  logic [14:0] sag_sum;
  logic [16:0] wq_full;
  logic [11:0] quot;
  logic [4:0]  qval;

  assign vsh = clamp_shift(cfg_i.vshift);
  assign csh = clamp_shift(cfg_i.cshift);

  // exponential averages
  assign vsum = 33'(vacc_q) - 33'(vacc_q >> vsh) + 33'(mult_q[MUL_W-1:0]);
  assign csum = 17'(cacc_q) - 17'(cacc_q >> csh) + 17'(cs_q);
  assign vacc_d = vsum[32] ? '1 : vsum[31:0];
  assign cacc_d = csum[16] ? '1 : csum[15:0];

  assign cshifted = cacc_q >> csh;
  assign cur_d    = (|cshifted[15:8]) ? '1 : cshifted[7:0];

  assign volt_d = (xv_q >= VOLT_SAT_LIM) ? V14_MAX : mult_q[RCP125_SH +: VOLT_W];

  assign sag_sum = 15'(volt_q) + 15'(mult_q[RCP125_SH +: 10]);
  assign sag_d   = sag_sum[14] ? V14_MAX : sag_sum[13:0];

  assign wq_full = mult_q[RCP25_SH +: 17];
  assign w_d     = wq_full[16] ? '1 : wq_full[15:0];

  // step size of displayed power
  always_comb begin
    if (w_q < WSTEP_LO) begin
      qsel_d = STEP_10;
    end else if (w_q < WSTEP_HI) begin
      qsel_d = STEP_20;
    end else begin
      qsel_d = STEP_25;
    end
  end

  always_comb begin
    case (qsel_q)
      STEP_10: begin
        quot = mult_q[RCP5_SH +: 12];
        qval = 5'd10;
      end
      STEP_20: begin
        quot = mult_q[RCP5_SH +: 12];
        qval = 5'd20;
      end
      default: begin
        quot = mult_q[RCP25_SH +: 12];
        qval = 5'd25;
      end
    endcase
  end

  // operand select of the shared multiplier
  always_comb begin
    unique case (cmd_i.op)
      OP_VSCALE: begin
        mul_a = MUL_W'(vs_q);
        mul_b = MUL_W'(cfg_i.vscale);
      end
      OP_VDIV: begin
        mul_a = MUL_W'(xv_q[23:3]);
        mul_b = RCP125;
      end
      OP_RCUR: begin
        mul_a = MUL_W'(cfg_i.rpack);
        mul_b = MUL_W'(cur_q);
      end
      OP_SDIV: begin
        mul_a = MUL_W'(mult_q[17:2]);
        mul_b = RCP125;
      end
      OP_PWR: begin
        mul_a = MUL_W'(volt_q);
        mul_b = MUL_W'(cur_q);
      end
      OP_WDIV: begin
        mul_a = MUL_W'(mult_q[21:1]);
        mul_b = RCP25;
      end
      OP_STEP: begin
        if (qsel_d == STEP_10) begin
          mul_a = MUL_W'(w_q[15:1]);
          mul_b = RCP5;
        end else if (qsel_d == STEP_20) begin
          mul_a = MUL_W'(w_q[15:2]);
          mul_b = RCP5;
        end else begin
          mul_a = MUL_W'(w_q);
          mul_b = RCP25;
        end
      end
      OP_QMUL: begin
        mul_a = MUL_W'(quot);
        mul_b = MUL_W'(qval);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vacc_q <= '0;
      cacc_q <= '0;
    end else if (cmd_i.acc_en) begin
      vacc_q <= vacc_d;
      cacc_q <= cacc_d;
    end
  end

  // working and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      vs_q <= voltage_sample_i[VsW-1:0];
      cs_q <= current_sample_i;
    end
    if (cmd_i.mul_en) begin
      mult_q <= mul_a * mul_b;
    end
    if (cmd_i.shf_en) begin
      xv_q  <= vacc_q >> vsh;
      cur_q <= cur_d;
    end
    if (cmd_i.volt_en) begin
      volt_q <= volt_d;
    end
    if (cmd_i.sag_en) begin
      sag_q <= sag_d;
    end
    if (cmd_i.pw_en) begin
      pw_q <= mult_q[PWR_W-1:0];
    end
    if (cmd_i.w_en) begin
      w_q <= w_d;
    end
    if (cmd_i.qsel_en) begin
      qsel_q <= qsel_d;
    end
    if (cmd_i.out_load) begin
      voltage_tenths_o     <= volt_q;
      current_fifths_o     <= cur_q;
      power_fiftieths_o    <= pw_q;
      power_watts_o        <= mult_q[WATT_W-1:0];
      sag_voltage_tenths_o <= sag_q;
    end
  end

endmodule

// ----- hdl/battery_telemetry_filter_unit.sv -----
// top level of the battery telemetry filter: configuration registers and
// the sequencer and datapath; depends on btf_pkg, btf_ctrl and btf_dpath
//
// One word holds a voltage ADC sample and a current sample; one result word
// follows each. The sequencer steps every multiply of a word through the one
// shared 24x24 multiplier (scaling, constant divisions by reciprocal, power
// and stepping).
// The input stalls while a word is in work; a finished result waits in its own
// output register, so the next word is taken while the last one is unread.
// Configuration writes are always ready and belong in idle periods.
module battery_telemetry_filter_unit #(
  parameter int unsigned AdcBits = btf_pkg::ADC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [btf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [btf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [btf_pkg::VSAMPLE_W-1:0]     voltage_sample_i,
  input  logic [btf_pkg::CSAMPLE_W-1:0]     current_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [btf_pkg::VOLT_W-1:0]        voltage_tenths_o,
  output logic [btf_pkg::CUR_W-1:0]         current_fifths_o,
  output logic [btf_pkg::PWR_W-1:0]         power_fiftieths_o,
  output logic [btf_pkg::WATT_W-1:0]        power_watts_o,
  output logic [btf_pkg::VOLT_W-1:0]        sag_voltage_tenths_o
);
  import btf_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vshift <= VSHIFT_RST;
      cfg_q.cshift <= CSHIFT_RST;
      cfg_q.vscale <= VSCALE_RST;
      cfg_q.rpack  <= RPACK_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_VSHIFT: cfg_q.vshift <= cfg_data_i[3:0];
        REG_CSHIFT: cfg_q.cshift <= cfg_data_i[3:0];
        REG_VSCALE: cfg_q.vscale <= cfg_data_i[13:0];
        REG_RPACK:  cfg_q.rpack  <= cfg_data_i[9:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  btf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  btf_dpath #(
    .AdcBits (AdcBits)
  ) u_dpath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .cfg_i                (cfg_q),
    .voltage_sample_i     (voltage_sample_i),
    .current_sample_i     (current_sample_i),
    .voltage_tenths_o     (voltage_tenths_o),
    .current_fifths_o     (current_fifths_o),
    .power_fiftieths_o    (power_fiftieths_o),
    .power_watts_o        (power_watts_o),
    .sag_voltage_tenths_o (sag_voltage_tenths_o)
  );

endmodule
